### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### sv/hrc_pkg.sv
// ---------------------------------------------------------------------------
// hrc_pkg
// Types, widths, register indexes and reset values for the Hampel clamp.
// ---------------------------------------------------------------------------
package hrc_pkg;

	// geometry
	localparam int AXIS_COUNT  = 3;
	localparam int SAMPLE_BITS = 32;
	localparam int AX_W        = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

	// register widths and fixed-point fraction bits
	localparam int STEP_W    = 16;
	localparam int GAIN_W    = 16;
	localparam int FLOOR_W   = 31;
	localparam int MODE_W    = 8;
	localparam int FRAC_STEP = 16;
	localparam int FRAC_GAIN = 8;

	// shared multiplier: signed operand times unsigned 16-bit coefficient
	localparam int MUL_A_W = SAMPLE_BITS + 2;
	localparam int MUL_B_W = 16;
	localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = FLOOR_W;

	localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 2'd2;

	localparam logic [STEP_W-1:0]  STEP_RST  = 16'd1966;
	localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd1280;
	localparam logic [FLOOR_W-1:0] FLOOR_RST = 31'd1;

	// payload of one input item
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_x;
		logic signed [SAMPLE_BITS-1:0] sample_y;
		logic signed [SAMPLE_BITS-1:0] sample_z;
		logic [MODE_W-1:0]             flight_mode;
	} in_t;

	// payload of one result item
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] filtered_x;
		logic signed [SAMPLE_BITS-1:0] filtered_y;
		logic signed [SAMPLE_BITS-1:0] filtered_z;
		logic                          was_reseeded;
	} out_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_C,
		ST_MUL_S,
		ST_FLOOR,
		ST_MUL_H,
		ST_BOUND,
		ST_CLAMP,
		ST_DONE
	} state_t;

	// multiplier operand select
	typedef enum logic [1:0] {
		MSEL_CENTRE,
		MSEL_SPREAD,
		MSEL_HALF
	} msel_t;

	// sequencer to datapath
	typedef struct packed {
		logic  in_ready;
		logic  mul_go;
		msel_t msel;
		logic  dev_we;
		logic  centre_we;
		logic  spread_we;
		logic  bound_we;
		logic  res_we;
		logic  ax_inc;
		logic  out_load;
	} ctl_t;

	// datapath to sequencer
	typedef struct packed {
		logic in_valid;
		logic reseed;
		logic last_axis;
		logic out_free;
	} sts_t;

endpackage

### sv/hrc_mul.sv
// ---------------------------------------------------------------------------
// hrc_mul
// Shared signed-by-unsigned multiplier with a registered product.
// ---------------------------------------------------------------------------
module hrc_mul (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [hrc_pkg::MUL_A_W-1:0]   a,
	input  logic        [hrc_pkg::MUL_B_W-1:0]   b,
	output logic signed [hrc_pkg::PROD_W-1:0]    p
);

	logic signed [hrc_pkg::PROD_W-1:0] p_q;

	// coefficient is unsigned: extend with a zero sign bit
	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * $signed({1'b0, b});
		end
	end

	assign p = p_q;

endmodule

### sv/hrc_fsm.sv
// ---------------------------------------------------------------------------
// hrc_fsm
// Sequencer: walks each axis through the multiply, floor, bound and clamp
// steps (a reseeding item skips them), then hands the result to the output register.
// ---------------------------------------------------------------------------
module hrc_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  hrc_pkg::sts_t     sts,
	output hrc_pkg::ctl_t     ctl
);

	hrc_pkg::state_t state_q;
	hrc_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hrc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hrc_pkg::ST_IDLE: begin
				if (sts.in_valid) begin
					state_d = sts.reseed ? hrc_pkg::ST_DONE : hrc_pkg::ST_MUL_C;
				end
			end
			hrc_pkg::ST_MUL_C: state_d = hrc_pkg::ST_MUL_S;
			hrc_pkg::ST_MUL_S: state_d = hrc_pkg::ST_FLOOR;
			hrc_pkg::ST_FLOOR: state_d = hrc_pkg::ST_MUL_H;
			hrc_pkg::ST_MUL_H: state_d = hrc_pkg::ST_BOUND;
			hrc_pkg::ST_BOUND: state_d = hrc_pkg::ST_CLAMP;
			hrc_pkg::ST_CLAMP: begin
				state_d = sts.last_axis ? hrc_pkg::ST_DONE : hrc_pkg::ST_MUL_C;
			end
			hrc_pkg::ST_DONE: begin
				if (sts.out_free) begin
					state_d = hrc_pkg::ST_IDLE;
				end
			end
			default: state_d = hrc_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		ctl = '0;
		ctl.msel = hrc_pkg::MSEL_CENTRE;
		unique case (state_q)
			hrc_pkg::ST_IDLE: ctl.in_ready = 1'b1;
			hrc_pkg::ST_MUL_C: begin
				ctl.mul_go = 1'b1;
				ctl.msel   = hrc_pkg::MSEL_CENTRE;
				ctl.dev_we = 1'b1;
			end
			hrc_pkg::ST_MUL_S: begin
				ctl.mul_go    = 1'b1;
				ctl.msel      = hrc_pkg::MSEL_SPREAD;
				ctl.centre_we = 1'b1;
			end
			hrc_pkg::ST_FLOOR: ctl.spread_we = 1'b1;
			hrc_pkg::ST_MUL_H: begin
				ctl.mul_go = 1'b1;
				ctl.msel   = hrc_pkg::MSEL_HALF;
			end
			hrc_pkg::ST_BOUND: ctl.bound_we = 1'b1;
			hrc_pkg::ST_CLAMP: begin
				ctl.res_we = 1'b1;
				ctl.ax_inc = !sts.last_axis;
			end
			hrc_pkg::ST_DONE: ctl.out_load = sts.out_free;
			default: ctl = '0;
		endcase
	end

endmodule

### sv/recursive_hampel_clamp_3axis.sv
// ---------------------------------------------------------------------------
// recursive_hampel_clamp_3axis
// Three-axis recursive Hampel outlier clamp for accelerometer samples.
//
// Input channel in_valid/in_ready/in_data carries three Q16.16 samples and
// a flight-mode code. Output channel out_valid/out_ready/out_data carries
// the clamped samples and a reseed flag. Configuration writes arrive on
// cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high and
// index 0 is step_size, 1 clamp_gain, 2 spread_floor, others are ignored.
//
// A reseeding item (first item, or a new flight mode) passes its samples
// straight to the output register. Any other item runs every axis through one
// shared multiplier in six steps before its result is loaded. in_ready stays
// low from acceptance until the result is loaded.
// Reset returns the configuration to its defaults and clears the seeded
// flag, so the next item reseeds. A stalled result waits in the output
// register; one more item may be accepted and worked on, and it then
// waits until that register is taken.
// ---------------------------------------------------------------------------
module recursive_hampel_clamp_3axis (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  hrc_pkg::in_t                        in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output hrc_pkg::out_t                       out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hrc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hrc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int SB = hrc_pkg::SAMPLE_BITS;
	localparam int NA = hrc_pkg::AXIS_COUNT;

	hrc_pkg::ctl_t ctl;
	hrc_pkg::sts_t sts;

	// configuration registers
	logic [hrc_pkg::STEP_W-1:0]  step_q;
	logic [hrc_pkg::GAIN_W-1:0]  gain_q;
	logic [hrc_pkg::FLOOR_W-1:0] floor_q;

	// filter state and item registers
	logic signed [SB-1:0]         centre_q [NA];
	logic        [SB-1:0]         spread_q [NA];
	logic signed [SB-1:0]         samp_q   [NA];
	logic signed [SB-1:0]         res_q    [NA];
	logic [hrc_pkg::MODE_W-1:0]   last_mode_q;
	logic                         seeded_q;
	logic                         reseed_q;
	logic [hrc_pkg::AX_W-1:0]     ax_q;
	logic [SB-1:0]                dev_q;
	logic signed [SB-1:0]         lower_q;
	logic signed [SB-1:0]         upper_q;
	logic                         out_valid_q;
	hrc_pkg::out_t                out_q;

	// combinational datapath
	logic signed [SB-1:0]              in_samp [NA];
	logic                              accept;
	logic                              reseed_d;
	logic [SB-1:0]                     fl_ext;
	logic signed [SB-1:0]              cur_s;
	logic signed [SB-1:0]              cur_c;
	logic        [SB-1:0]              cur_sp;
	logic signed [SB:0]                diff;
	logic signed [SB:0]                diff_neg;
	logic        [SB-1:0]              dev_d;
	logic signed [hrc_pkg::MUL_A_W-1:0] mul_a;
	logic        [hrc_pkg::MUL_B_W-1:0] mul_b;
	logic signed [hrc_pkg::PROD_W-1:0]  prod;
	logic        [SB-1:0]              step_part;
	logic signed [SB-1:0]              nc_d;
	logic        [SB-1:0]              ns_d;
	logic        [SB-1:0]              nsu_d;
	logic        [SB-1:0]              half_d;
	logic signed [SB+1:0]              lo_w;
	logic signed [SB+1:0]              hi_w;
	logic signed [SB-1:0]              lower_d;
	logic signed [SB-1:0]              upper_d;
	logic signed [SB-1:0]              r_d;

	assign in_samp[0] = in_data.sample_x;
	assign in_samp[1] = in_data.sample_y;
	assign in_samp[2] = in_data.sample_z;

	assign accept    = in_valid && ctl.in_ready;
	assign reseed_d  = !seeded_q || (in_data.flight_mode != last_mode_q);
	assign fl_ext    = SB'(floor_q);

	// current axis operands
	assign cur_s  = samp_q[ax_q];
	assign cur_c  = centre_q[ax_q];
	assign cur_sp = spread_q[ax_q];

	// deviation from the old centre, exact
	assign diff     = {cur_s[SB-1], cur_s} - {cur_c[SB-1], cur_c};
	assign diff_neg = -diff;
	assign dev_d    = diff[SB] ? diff_neg[SB-1:0] : diff[SB-1:0];

	// multiplier operand select
	always_comb begin
		mul_a = {diff[SB], diff};
		mul_b = step_q;
		case (ctl.msel)
			hrc_pkg::MSEL_CENTRE: begin
				mul_a = {diff[SB], diff};
				mul_b = step_q;
			end
			hrc_pkg::MSEL_SPREAD: begin
				mul_a = {2'b00, dev_q} - {2'b00, cur_sp};
				mul_b = step_q;
			end
			hrc_pkg::MSEL_HALF: begin
				mul_a = {2'b00, cur_sp};
				mul_b = gain_q;
			end
			default: begin
				mul_a = {diff[SB], diff};
				mul_b = step_q;
			end
		endcase
	end

	hrc_mul u_mul (
		.clk (clk),
		.en  (ctl.mul_go),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// floored step product; the updated values stay in range, so wrap is exact
	assign step_part = prod[SB+hrc_pkg::FRAC_STEP-1:hrc_pkg::FRAC_STEP];
	assign nc_d      = cur_c + $signed(step_part);
	assign ns_d      = cur_sp + step_part;
	assign nsu_d     = (ns_d < fl_ext) ? fl_ext : ns_d;

	// clamp half-width, saturated to the sample width
	assign half_d = (|prod[hrc_pkg::PROD_W-1:SB+hrc_pkg::FRAC_GAIN]) ? '1 :
		prod[SB+hrc_pkg::FRAC_GAIN-1:hrc_pkg::FRAC_GAIN];

	// bounds around the new centre, saturated at the signed range
	assign lo_w = {{2{cur_c[SB-1]}}, cur_c} - {2'b00, half_d};
	assign hi_w = {{2{cur_c[SB-1]}}, cur_c} + {2'b00, half_d};
	assign lower_d = (lo_w[SB+1:SB-1] == {3{lo_w[SB+1]}}) ? lo_w[SB-1:0] :
		{1'b1, {(SB-1){1'b0}}};
	assign upper_d = (hi_w[SB+1:SB-1] == {3{hi_w[SB+1]}}) ? hi_w[SB-1:0] :
		{1'b0, {(SB-1){1'b1}}};

	// clamp the sample
	assign r_d = (cur_s < lower_q) ? lower_q :
		(cur_s > upper_q) ? upper_q : cur_s;

	// status to the sequencer
	assign sts.in_valid  = in_valid;
	assign sts.reseed    = reseed_d;
	assign sts.last_axis = (ax_q == hrc_pkg::AX_W'(NA - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	hrc_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	// control registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= hrc_pkg::STEP_RST;
			gain_q      <= hrc_pkg::GAIN_RST;
			floor_q     <= hrc_pkg::FLOOR_RST;
			last_mode_q <= '0;
			seeded_q    <= 1'b0;
			ax_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					hrc_pkg::CFG_STEP:  step_q  <= cfg_data[hrc_pkg::STEP_W-1:0];
					hrc_pkg::CFG_GAIN:  gain_q  <= cfg_data[hrc_pkg::GAIN_W-1:0];
					hrc_pkg::CFG_FLOOR: floor_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				seeded_q    <= 1'b1;
				last_mode_q <= in_data.flight_mode;
				ax_q        <= '0;
			end else if (ctl.ax_inc) begin
				ax_q <= ax_q + hrc_pkg::AX_W'(1);
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			reseed_q <= reseed_d;
			for (int i = 0; i < NA; i++) begin
				samp_q[i] <= in_samp[i];
				if (reseed_d) begin
					centre_q[i] <= in_samp[i];
					spread_q[i] <= fl_ext;
					res_q[i]    <= in_samp[i];
				end
			end
		end
		if (ctl.dev_we) begin
			dev_q <= dev_d;
		end
		if (ctl.centre_we) begin
			centre_q[ax_q] <= nc_d;
		end
		if (ctl.spread_we) begin
			spread_q[ax_q] <= nsu_d;
		end
		if (ctl.bound_we) begin
			lower_q <= lower_d;
			upper_q <= upper_d;
		end
		if (ctl.res_we) begin
			res_q[ax_q] <= r_d;
		end
		if (ctl.out_load) begin
			out_q.filtered_x   <= res_q[0];
			out_q.filtered_y   <= res_q[1];
			out_q.filtered_z   <= res_q[2];
			out_q.was_reseeded <= reseed_q;
		end
	end

	assign in_ready  = ctl.in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### sv/hrc_chk.sv
// ---------------------------------------------------------------------------
// hrc_chk
// Port-level checker for the Hampel clamp, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hrc_chk (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  hrc_pkg::out_t                   out_data,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready
);

	// an accepted item keeps the sequencer busy in the following cycle
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// a new result comes only out of a busy cycle
	`ASSERT_IMPL(a_result_from_busy, clk, arst_n, $rose(out_valid), $past(!in_ready))

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// the configuration port never stalls
	`ASSERT_IMPL(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind recursive_hampel_clamp_3axis hrc_chk u_hrc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

### tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the three-axis recursive Hampel clamp. Samples go
// in on a valid/ready channel and every clamped result is checked against an
// in-bench model of the centre/spread tracking. Both ends idle at random, and
// the registers are rewritten between phases, the extremes included.
// ---------------------------------------------------------------------------
module tb;
	import hrc_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int TAIL_CYCLES  = 40;
	localparam int JUNK_W       = CFG_DATA_W - STEP_W;

	// index past the register list, must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 32'sh8000_0000;
	localparam longint SAMPLE_HI   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_LO   = -SAMPLE_HI - 1;
	localparam longint SAMPLE_SPAN = (longint'(1) <<< SAMPLE_BITS) - 1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_t                   in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_t                  out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// model copy of the registers and the filter state
	logic [STEP_W-1:0]  step_reg  = STEP_RST;
	logic [GAIN_W-1:0]  gain_reg  = GAIN_RST;
	logic [FLOOR_W-1:0] floor_reg = FLOOR_RST;
	longint             centre_est [AXIS_COUNT];
	longint             spread_est [AXIS_COUNT];
	logic [MODE_W-1:0]  mode_last = '0;
	bit                 seeded = 1'b0;

	out_t pending_results [$];

	// traffic shaping
	bit          calm = 1'b0;
	int unsigned tx_gap_pct = 20;
	int unsigned rx_stall_pct = 20;
	int unsigned rx_hold = 0;

	// stimulus generator state
	logic [MODE_W-1:0]             gen_mode = '0;
	logic signed [SAMPLE_BITS-1:0] axis_trend [AXIS_COUNT];

	int mismatches = 0;
	int sent_count = 0;
	int checked_count = 0;
	int reseed_count = 0;
	int setting_count = 0;
	int cycle_count = 0;

	always #5 clk = ~clk;

	recursive_hampel_clamp_3axis i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// expected result of one accepted sample; advances the model state
	function automatic out_t predict_filtered(in_t item);
		out_t   res;
		longint smp [AXIS_COUNT];
		logic signed [SAMPLE_BITS-1:0] filt [AXIS_COUNT];
		longint diff, dev, nc, ns, half, lower, upper, r;
		smp[0] = item.sample_x;
		smp[1] = item.sample_y;
		smp[2] = item.sample_z;
		// first sample or new flight mode: reseed and pass through
		if (!seeded || item.flight_mode != mode_last) begin
			seeded = 1'b1;
			mode_last = item.flight_mode;
			for (int i = 0; i < AXIS_COUNT; i++) begin
				centre_est[i] = smp[i];
				spread_est[i] = longint'(floor_reg);
			end
			res.filtered_x = item.sample_x;
			res.filtered_y = item.sample_y;
			res.filtered_z = item.sample_z;
			res.was_reseeded = 1'b1;
			reseed_count++;
			return res;
		end
		for (int i = 0; i < AXIS_COUNT; i++) begin
			diff = smp[i] - centre_est[i];
			dev = (diff < 0) ? -diff : diff;
			nc = centre_est[i] + ((diff * longint'(step_reg)) >>> FRAC_STEP);
			ns = spread_est[i] + (((dev - spread_est[i]) * longint'(step_reg)) >>> FRAC_STEP);
			if (ns < 0)
				ns = 0;
			if (ns < longint'(floor_reg))
				ns = longint'(floor_reg);
			half = (longint'(gain_reg) * ns) >>> FRAC_GAIN;
			if (half > SAMPLE_SPAN)
				half = SAMPLE_SPAN;
			// bounds saturate at the sample range
			lower = nc - half;
			upper = nc + half;
			if (lower < SAMPLE_LO)
				lower = SAMPLE_LO;
			if (upper > SAMPLE_HI)
				upper = SAMPLE_HI;
			r = smp[i];
			if (r < lower)
				r = lower;
			if (r > upper)
				r = upper;
			centre_est[i] = nc;
			spread_est[i] = ns;
			filt[i] = r[SAMPLE_BITS-1:0];
		end
		res.filtered_x = filt[0];
		res.filtered_y = filt[1];
		res.filtered_z = filt[2];
		res.was_reseeded = 1'b0;
		return res;
	endfunction

	function automatic in_t mk_item(logic signed [SAMPLE_BITS-1:0] x,
			logic signed [SAMPLE_BITS-1:0] y, logic signed [SAMPLE_BITS-1:0] z,
			logic [MODE_W-1:0] mode);
		in_t item;
		item.sample_x = x;
		item.sample_y = y;
		item.sample_z = z;
		item.flight_mode = mode;
		return item;
	endfunction

	// mostly noise around a trend, sometimes outliers and range extremes
	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
			logic signed [SAMPLE_BITS-1:0] around);
		int noise;
		noise = int'($urandom_range(0, 262143)) - 131072;
		case ($urandom_range(0, 15))
			0:       return $urandom;
			1:       return S_MAX;
			2:       return S_MIN;
			3:       return around + (int'($urandom_range(0, 67108863)) - 33554432);
			default: return around + noise;
		endcase
	endfunction

	function automatic in_t make_random_item();
		in_t         item;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		// occasional change of flight state, new trends with it
		if (roll < 4) begin
			gen_mode = MODE_W'($urandom_range(0, 255));
			for (int i = 0; i < AXIS_COUNT; i++)
				axis_trend[i] = $urandom;
		end
		for (int i = 0; i < AXIS_COUNT; i++)
			axis_trend[i] = axis_trend[i] + (int'($urandom_range(0, 8191)) - 4096);
		item.sample_x = pick_sample(axis_trend[0]);
		item.sample_y = pick_sample(axis_trend[1]);
		item.sample_z = pick_sample(axis_trend[2]);
		// a stray mode on a single item breaks the sequence
		item.flight_mode = (roll == 4) ? MODE_W'($urandom) : gen_mode;
		return item;
	endfunction

	// send one item; valid stays high afterwards unless the next call idles
	task automatic send_sample(in_t item);
		if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_filtered(item));
		sent_count++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_STEP:  step_reg = value[STEP_W-1:0];
			CFG_GAIN:  gain_reg = value[GAIN_W-1:0];
			CFG_FLOOR: floor_reg = value;
			default:   ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// new register setting once the block has gone idle; junk in unused bits
	task automatic set_config(logic [STEP_W-1:0] step, logic [GAIN_W-1:0] gain,
			logic [FLOOR_W-1:0] spread_min);
		logic [JUNK_W-1:0] junk;
		wait_idle();
		junk = JUNK_W'($urandom);
		write_reg(CFG_STEP, {junk, step});
		junk = JUNK_W'($urandom);
		write_reg(CFG_GAIN, {junk, gain});
		write_reg(CFG_FLOOR, spread_min);
		setting_count++;
	endtask

	task automatic run_random_items(int count);
		for (int n = 0; n < count; n++)
			send_sample(make_random_item());
	endtask

	// ---- tests -------------------------------------------------------------

	// reset values, first-sample reseed, mode changes, field extremes
	task automatic test_reseed_and_defaults();
		send_sample(mk_item(32'sh0001_0000, 32'shFFFF_0000, 32'sd0, 8'h00));
		send_sample(mk_item(32'sh0001_0100, 32'shFFFE_FF00, 32'sd1, 8'h00));
		send_sample(mk_item(S_MAX, S_MIN, 32'sd0, 8'h00));
		send_sample(mk_item(S_MIN, S_MAX, -32'sd1, 8'h00));
		send_sample(mk_item(S_MAX, S_MIN, 32'sh5555_5555, 8'hFF));
		send_sample(mk_item(32'shAAAA_AAAA, 32'sd0, 32'sd1, 8'hFF));
		send_sample(mk_item(-32'sd1, S_MAX, S_MIN, 8'h00));
	endtask

	// zero step: centre and spread hold, spread only floored
	task automatic test_zero_step();
		set_config(16'd0, GAIN_RST, 31'd65536);
		send_sample(mk_item(32'sh0100_0000, 32'shFF00_0000, S_MAX, 8'h00));
		send_sample(mk_item(S_MIN, 32'sd12345, 32'sd0, 8'h00));
		send_sample(mk_item(32'sd0, S_MAX, -32'sd1, 8'h00));
	endtask

	// zero gain: output collapses onto the new centre
	task automatic test_zero_gain();
		set_config(16'd20000, 16'd0, FLOOR_RST);
		send_sample(mk_item(32'sh0004_0000, 32'shFFFC_0000, S_MIN, 8'h00));
		send_sample(mk_item(S_MAX, 32'sd7, 32'sh1234_5678, 8'h00));
		send_sample(mk_item(32'sd3, S_MIN, S_MAX, 8'h00));
	endtask

	// widest bounds saturate at the range limits
	task automatic test_wide_bounds();
		set_config(16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF);
		send_sample(mk_item(32'sd0, 32'sd0, 32'sd0, 8'h5A));
		send_sample(mk_item(S_MAX, S_MIN, S_MAX, 8'h5A));
		send_sample(mk_item(S_MIN, S_MAX, 32'sd0, 8'h5A));
		send_sample(mk_item(S_MAX, S_MAX, S_MIN, 8'h5A));
	endtask

	// a write past the register list changes nothing
	task automatic test_ignored_index();
		wait_idle();
		write_reg(CFG_UNUSED, 31'h7FFF_FFFF);
		send_sample(mk_item(32'sh0000_8000, 32'shFFFF_8000, 32'sd0, 8'h5A));
		send_sample(mk_item(32'sh7000_0000, 32'sh9000_0000, 32'sd5, 8'h5A));
	endtask

	// random sequences under a series of settings and idling mixes
	task automatic test_random_traffic();
		logic [STEP_W-1:0]  step;
		logic [GAIN_W-1:0]  gain;
		logic [FLOOR_W-1:0] spread_min;
		int unsigned        mix [4];
		mix = '{0, 15, 40, 70};
		for (int phase = 0; phase < 7; phase++) begin
			step = STEP_W'($urandom_range(0, 65535));
			gain = GAIN_W'($urandom_range(0, 65535));
			spread_min = FLOOR_W'($urandom_range(0, 1 << 20));
			case (phase)
				0: begin step = STEP_RST; gain = GAIN_RST; spread_min = FLOOR_RST; end
				1: begin step = 16'd0; spread_min = 31'd65536; end
				2: begin step = 16'hFFFF; gain = 16'hFFFF; spread_min = 31'd1; end
				3: gain = 16'd0;
				4: spread_min = 31'd0;
				5: spread_min = 31'h7FFF_FFFF;
				default: spread_min = FLOOR_W'($urandom);
			endcase
			set_config(step, gain, spread_min);
			tx_gap_pct = mix[$urandom_range(0, 3)];
			rx_stall_pct = mix[$urandom_range(0, 3)];
			run_random_items(140);
		end
	endtask

	// back-to-back traffic with no idling on either side
	task automatic test_steady_stream();
		calm = 1'b1;
		set_config(STEP_W'($urandom), GAIN_W'($urandom),
			FLOOR_W'($urandom_range(0, 1 << 18)));
		run_random_items(120);
	endtask

	// ---- result side ---------------------------------------------------------

	// random stall bursts on the result channel
	always @(posedge clk) begin
		if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
		end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
			out_ready <= 1'b0;
			rx_hold <= $urandom_range(0, 11);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic compare_field(string name, logic signed [SAMPLE_BITS-1:0] want,
			logic signed [SAMPLE_BITS-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// each accepted result against the oldest expectation
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result item with none expected");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				compare_field("filtered_x", want.filtered_x, out_data.filtered_x);
				compare_field("filtered_y", want.filtered_y, out_data.filtered_y);
				compare_field("filtered_z", want.filtered_z, out_data.filtered_z);
				compare_field("was_reseeded", SAMPLE_BITS'(want.was_reseeded),
					SAMPLE_BITS'(out_data.was_reseeded));
				checked_count++;
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("timeout after %0d cycles", cycle_count);
		$display("tb NOT OK");
		$finish;
	end

	// ---- sequence --------------------------------------------------------------

	initial begin
		for (int i = 0; i < AXIS_COUNT; i++) begin
			centre_est[i] = 0;
			spread_est[i] = 0;
			axis_trend[i] = $urandom;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reseed_and_defaults();
		test_zero_step();
		test_zero_gain();
		test_wide_bounds();
		test_ignored_index();
		test_random_traffic();
		test_steady_stream();

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			mismatches++;
		end
		$display("Ran %0d samples (%0d reseeds) through %0d register settings,",
			sent_count, reseed_count, setting_count);
		$display("checked %0d results with random stalls on both channels.",
			checked_count);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
